// ===== rtl/csi_pkg.sv =====
package csi_pkg;

  typedef struct packed {
    logic        func;
    logic [2:0]  particle_kind;
    logic [2:0]  process_kind;
    logic        current_kind;
    logic [9:0]  point_index;
    logic [23:0] energy;
    logic [23:0] section_value;
  } in_req_t;

  typedef struct packed {
    logic [63:0] rate_weight;
    logic [1:0]  range_status;
  } out_req_t;

  localparam logic       FUNC_WRITE = 1'b0;
  localparam logic       FUNC_QUERY = 1'b1;
  localparam logic [2:0] KIND_MAX   = 3'd5;

  localparam logic [1:0] ST_INTERP = 2'd0;
  localparam logic [1:0] ST_BELOW  = 2'd1;
  localparam logic [1:0] ST_ABOVE  = 2'd2;

  localparam logic        CFG_POINTS = 1'b0;
  localparam logic        CFG_SCALE  = 1'b1;
  localparam logic [10:0] POINTS_RESET = 11'd1024;
  localparam logic [31:0] SCALE_RESET  = 32'd2778766069;

  localparam logic [5:0] DIV_LAST = 6'd48;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_FIRST,
    OP_CHECK,
    OP_SCAN,
    OP_MUL0,
    OP_MUL1,
    OP_DIV,
    OP_SE,
    OP_SC0,
    OP_SC1,
    OP_SUM
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic is_query;
    logic bad;
    logic out_range;
    logic hit;
    logic dzero;
    logic scan_end;
    logic div_done;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== rtl/csi_ctrl.sv =====
module csi_ctrl
  import csi_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_FIRST = 11'b00000000010,
    S_CHECK = 11'b00000000100,
    S_SCAN  = 11'b00000001000,
    S_MUL0  = 11'b00000010000,
    S_MUL1  = 11'b00000100000,
    S_DIV   = 11'b00001000000,
    S_SE    = 11'b00010000000,
    S_SC0   = 11'b00100000000,
    S_SC1   = 11'b01000000000,
    S_SUM   = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = OP_ACCEPT;
          if (stat.is_query) begin
            state_nxt = stat.bad ? S_SE : S_FIRST;
          end
        end
      end
      S_FIRST: begin
        cmd.op    = OP_FIRST;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cmd.op    = OP_CHECK;
        state_nxt = stat.out_range ? S_SE : S_SCAN;
      end
      S_SCAN: begin
        cmd.op = OP_SCAN;
        if (stat.hit) begin
          state_nxt = stat.dzero ? S_SE : S_MUL0;
        end else if (stat.scan_end) begin
          state_nxt = S_SE;
        end
      end
      S_MUL0: begin
        cmd.op    = OP_MUL0;
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        cmd.op    = OP_MUL1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op = OP_DIV;
        if (stat.div_done) begin
          state_nxt = S_SE;
        end
      end
      S_SE: begin
        cmd.op    = OP_SE;
        state_nxt = S_SC0;
      end
      S_SC0: begin
        cmd.op    = OP_SC0;
        state_nxt = S_SC1;
      end
      S_SC1: begin
        cmd.op    = OP_SC1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        if (stat.out_free) begin
          cmd.op    = OP_SUM;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/csi_datapath.sv =====
module csi_datapath
  import csi_pkg::*;
#(
  parameter int POINTS = 1024,
  parameter int CURVES = 72
) (
  input  logic        clk,
  input  logic        rst_n,
  input  in_req_t     in_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        out_stall,
  output logic        out_valid,
  output out_req_t    out_data,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat
);

  localparam int IW    = (POINTS > 2) ? $clog2(POINTS) : 1;
  localparam int CVW   = (CURVES > 1) ? $clog2(CURVES) : 1;
  localparam int AW    = CVW + IW;
  localparam int DEPTH = CURVES << IW;
  localparam int NW    = $clog2(POINTS + 1);
  localparam int CW    = (NW > 11) ? NW : 11;

  // table: energy in the upper half, cross section in the lower half
  logic [47:0] mem [0:DEPTH-1];
  logic [47:0] rdata_r;

  logic [10:0] pin_r;
  logic [31:0] scale_r;

  logic [CVW-1:0] curve_r;
  logic [23:0]    en_r;
  logic [23:0]    last_e_r, last_s_r;
  logic [23:0]    prev_e_r, prev_s_r;
  logic [IW-1:0]  j_r;
  logic [23:0]    d_r, t_r, slo_r, shi_r;
  logic [48:0]    acc_r, num_r;
  logic [23:0]    rem_r;
  logic [5:0]     cnt_r;
  logic [23:0]    sig_r, eop_r;
  logic [47:0]    se_r;
  logic [55:0]    hi_r, lo_r;
  logic [1:0]     stat_r;
  logic           out_valid_r;
  out_req_t       out_r;

  // request decode
  logic [6:0]  cv;
  logic        bad;
  logic        pidx_ok;
  assign cv      = (7'({4'b0, in_data.particle_kind}) * 7'd6
                   + 7'({4'b0, in_data.process_kind})) * 7'd2
                   + 7'({6'b0, in_data.current_kind});
  assign bad     = (in_data.particle_kind > KIND_MAX) || (in_data.process_kind > KIND_MAX)
                   || (32'(cv) >= CURVES);
  assign pidx_ok = (32'(in_data.point_index) < POINTS);

  // last point index, n clamped to 2..POINTS
  logic [CW-1:0] pin_ext;
  logic [IW-1:0] n_last;
  always_comb begin
    pin_ext = CW'(pin_r);
    if (pin_ext < CW'(2)) begin
      n_last = IW'(1);
    end else if (pin_ext > CW'(POINTS)) begin
      n_last = IW'(POINTS - 1);
    end else begin
      n_last = IW'(pin_ext - CW'(1));
    end
  end

  logic [23:0] rd_e, rd_s;
  assign rd_e = rdata_r[47:24];
  assign rd_s = rdata_r[23:0];

  // read address
  logic [IW-1:0]  rd_idx;
  logic [CVW-1:0] rd_curve;
  always_comb begin
    rd_curve = curve_r;
    case (cmd.op)
      OP_ACCEPT: begin
        rd_idx   = n_last;
        rd_curve = cv[CVW-1:0];
      end
      OP_FIRST: rd_idx = '0;
      OP_CHECK: rd_idx = IW'(1);
      default:  rd_idx = j_r + IW'(1);
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_ACCEPT && in_data.func == FUNC_WRITE && !bad && pidx_ok) begin
      mem[{cv[CVW-1:0], IW'(in_data.point_index)}] <= {in_data.energy, in_data.section_value};
    end
    rdata_r <= mem[{rd_curve, rd_idx}];
  end

  // scan compare
  logic hit;
  logic [23:0] dcur;
  assign hit  = (prev_e_r <= en_r) && (en_r <= rd_e);
  assign dcur = rd_e - prev_e_r;

  logic above, below;
  assign above = (en_r > last_e_r);
  assign below = (en_r < rd_e);

  // shared 24x32 multiplier
  logic [23:0] mul_a;
  logic [31:0] mul_b;
  logic [55:0] mul_p;
  always_comb begin
    mul_a = sig_r;
    mul_b = {8'b0, eop_r};
    case (cmd.op)
      OP_MUL0: begin
        mul_a = slo_r;
        mul_b = {8'b0, d_r - t_r};
      end
      OP_MUL1: begin
        mul_a = shi_r;
        mul_b = {8'b0, t_r};
      end
      OP_SC0: begin
        mul_a = se_r[47:24];
        mul_b = scale_r;
      end
      OP_SC1: begin
        mul_a = se_r[23:0];
        mul_b = scale_r;
      end
      default: ;
    endcase
  end
  assign mul_p = 56'(mul_a) * 56'(mul_b);

  // restoring divide step
  logic [24:0] rem_sh;
  logic        qbit;
  logic [24:0] rem_nx;
  logic [48:0] num_nx;
  always_comb begin
    rem_sh = {rem_r, num_r[48]};
    qbit   = (rem_sh >= {1'b0, d_r});
    rem_nx = qbit ? (rem_sh - {1'b0, d_r}) : rem_sh;
    num_nx = {num_r[47:0], qbit};
  end

  logic [79:0] full;
  assign full = {hi_r, 24'b0} + {24'b0, lo_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pin_r   <= POINTS_RESET;
      scale_r <= SCALE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_POINTS: pin_r   <= cfg_data[10:0];
        CFG_SCALE:  scale_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_ACCEPT: begin
        curve_r <= cv[CVW-1:0];
        en_r    <= in_data.energy;
        stat_r  <= ST_INTERP;
        sig_r   <= '0;
        eop_r   <= '0;
      end
      OP_FIRST: begin
        last_e_r <= rd_e;
        last_s_r <= rd_s;
      end
      OP_CHECK: begin
        prev_e_r <= rd_e;
        prev_s_r <= rd_s;
        j_r      <= IW'(1);
        if (above) begin
          sig_r  <= last_s_r;
          eop_r  <= last_e_r;
          stat_r <= ST_ABOVE;
        end else if (below) begin
          sig_r  <= rd_s;
          eop_r  <= rd_e;
          stat_r <= ST_BELOW;
        end else begin
          sig_r <= rd_s;
          eop_r <= en_r;
        end
      end
      OP_SCAN: begin
        if (hit) begin
          d_r   <= dcur;
          t_r   <= en_r - prev_e_r;
          slo_r <= prev_s_r;
          shi_r <= rd_s;
          if (dcur == 24'd0) begin
            sig_r <= prev_s_r;
          end
        end else begin
          prev_e_r <= rd_e;
          prev_s_r <= rd_s;
          j_r      <= j_r + IW'(1);
        end
      end
      OP_MUL0: acc_r <= mul_p[48:0];
      OP_MUL1: begin
        num_r <= acc_r + mul_p[48:0];
        rem_r <= '0;
        cnt_r <= '0;
      end
      OP_DIV: begin
        num_r <= num_nx;
        rem_r <= rem_nx[23:0];
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == DIV_LAST) begin
          sig_r <= num_nx[23:0];
        end
      end
      OP_SE:  se_r <= mul_p[47:0];
      OP_SC0: hi_r <= mul_p;
      OP_SC1: lo_r <= mul_p;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_SUM) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_SUM) begin
      out_r.rate_weight  <= {14'b0, full[79:30]};
      out_r.range_status <= stat_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    stat.is_query  = (in_data.func == FUNC_QUERY);
    stat.bad       = bad;
    stat.out_range = above || below;
    stat.hit       = hit;
    stat.dzero     = (dcur == 24'd0);
    stat.scan_end  = (j_r == n_last);
    stat.div_done  = (cnt_r == DIV_LAST);
    stat.out_free  = !out_valid_r || !out_stall;
  end

endmodule

// ===== rtl/cross_section_interpolator_core.sv =====
// Channel  Direction  Handshake             Payload
// in_      input      in_valid / in_stall   in_req_t  (write point or query)
// out_     output     out_valid / out_stall out_req_t (one per query)
// cfg_     input      cfg_we                cfg_index, cfg_data
//
// Write request: no result. Query: the time from accept to the next accept is set
// by the linear scan of the table memory (one point per read cycle) and the 49-step
// restoring divider for the interpolation.
// Zero-width bracket or no bracket skips the divide; out-of-range queries skip the
// scan and the divide, and invalid-kind queries also skip the table reads.
// Reset (rst_n low, synchronous) clears control and config; tables are not cleared.
// A result waits in the output register; new requests are still taken while it waits.
module cross_section_interpolator_core
  import csi_pkg::*;
#(
  parameter int POINTS = 1024,
  parameter int CURVES = 72
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_req_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_req_t    out_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: one request at a time
  csi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // table memory, shared multiplier, divider, output register
  csi_datapath #(
    .POINTS (POINTS),
    .CURVES (CURVES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
